FILE: hw/rtl/html_entity_escaper_top_macros.svh
// Assertion macros; clock clk, reset arst_n
`ifndef HTML_ENTITY_ESCAPER_TOP_MACROS_SVH
`define HTML_ENTITY_ESCAPER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define HEE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hee assertion failed");
`define HEE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hee assertion failed");
`else
`define HEE_ASSERT_SAME(lbl, ante, cons)
`define HEE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/hee_pkg.sv
package hee_pkg;

	localparam logic [3:0] ENT_NONE  = 4'd0;
	localparam logic [3:0] ENT_QUOT  = 4'd1;
	localparam logic [3:0] ENT_APOS  = 4'd2;
	localparam logic [3:0] ENT_AMP   = 4'd3;
	localparam logic [3:0] ENT_SLASH = 4'd4;
	localparam logic [3:0] ENT_LT    = 4'd5;
	localparam logic [3:0] ENT_EQ    = 4'd6;
	localparam logic [3:0] ENT_GT    = 4'd7;
	localparam logic [3:0] ENT_GRAVE = 4'd8;

	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_GRAVE = 8'h60;

	typedef struct packed {
		logic [3:0] code;
		logic [7:0] data;
		logic       last;
	} hee_item_t;

	function automatic logic [3:0] ent_classify(input logic [7:0] b);
		logic [3:0] c;
		unique case (b)
			CH_QUOT:  c = ENT_QUOT;
			CH_APOS:  c = ENT_APOS;
			CH_AMP:   c = ENT_AMP;
			CH_SLASH: c = ENT_SLASH;
			CH_LT:    c = ENT_LT;
			CH_EQ:    c = ENT_EQ;
			CH_GT:    c = ENT_GT;
			CH_GRAVE: c = ENT_GRAVE;
			default:  c = ENT_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] ent_len(input logic [3:0] code);
		logic [2:0] n;
		unique case (code)
			ENT_QUOT, ENT_APOS, ENT_SLASH, ENT_EQ: n = 3'd6;
			ENT_AMP:                               n = 3'd5;
			ENT_LT, ENT_GT:                        n = 3'd4;
			ENT_GRAVE:                             n = 3'd7;
			default:                               n = 3'd1;
		endcase
		return n;
	endfunction

	// entity text left-justified, byte 6 is the first character
	function automatic logic [7:0] ent_char(input logic [3:0] code, input logic [2:0] idx,
			input logic [7:0] data);
		logic [6:0][7:0] s;
		logic [7:0]      ch;
		unique case (code)
			ENT_QUOT:  s = {"&quot;", 8'h00};
			ENT_APOS:  s = {"&#x27;", 8'h00};
			ENT_AMP:   s = {"&amp;", 16'h0000};
			ENT_SLASH: s = {"&#x2F;", 8'h00};
			ENT_LT:    s = {"&lt;", 24'h000000};
			ENT_EQ:    s = {"&#x3D;", 8'h00};
			ENT_GT:    s = {"&gt;", 24'h000000};
			ENT_GRAVE: s = "&grave;";
			default:   s = '0;
		endcase
		if (code == ENT_NONE) begin
			ch = data;
		end else begin
			ch = s[3'(3'd6 - idx)];
		end
		return ch;
	endfunction

endpackage

FILE: hw/rtl/hee_front.sv
module hee_front
	import hee_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      text_byte,
	input  logic            text_last,
	input  logic            q_full,
	output logic            q_push,
	output hee_item_t       q_item
);

	logic      valid_s1;
	hee_item_t item_s1;
	logic      in_ready;

	assign in_ready = !valid_s1 || !q_full;
	assign full     = !in_ready;
	assign q_push   = valid_s1 && !q_full;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && push) begin
			item_s1.code <= ent_classify(text_byte);
			item_s1.data <= text_byte;
			item_s1.last <= text_last;
		end
	end

endmodule

FILE: hw/rtl/hee_queue.sv
`include "html_entity_escaper_top_macros.svh"

module hee_queue
	import hee_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  hee_item_t wr_item,
	output logic      q_full,
	input  logic      rd_en,
	output hee_item_t rd_item,
	output logic      q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hee_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_full  = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	`HEE_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
	`HEE_ASSERT_SAME(a_no_overflow, wr_en, !q_full)
	`HEE_ASSERT_SAME(a_no_underflow, rd_en, !q_empty)

endmodule

FILE: hw/rtl/hee_back.sv
`include "html_entity_escaper_top_macros.svh"

module hee_back
	import hee_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  hee_item_t  head,
	input  logic       q_empty,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] escaped_byte,
	output logic       run_last,
	output logic       text_end
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       run_last_q;
	logic       text_end_q;
	logic       load;
	logic       take;
	logic       fin;

	assign load  = !out_valid_q || pop;
	assign take  = load && !q_empty;
	assign fin   = (idx_q == 3'(ent_len(head.code) - 3'd1));
	assign q_pop = take && fin;

	assign empty        = !out_valid_q;
	assign escaped_byte = byte_q;
	assign run_last     = run_last_q;
	assign text_end     = text_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !q_empty;
			end
			if (take) begin
				idx_q <= fin ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q     <= ent_char(head.code, idx_q, head.data);
			run_last_q <= fin;
			text_end_q <= fin && head.last;
		end
	end

	`HEE_ASSERT_SAME(a_idx_bound, !q_empty, idx_q < ent_len(head.code))
	`HEE_ASSERT_SAME(a_mid_run_has_item, idx_q != 3'd0, !q_empty)
	`HEE_ASSERT_SAME(a_end_on_run_last, out_valid_q && text_end_q, run_last_q)

endmodule

FILE: hw/rtl/html_entity_escaper_top.sv
// Channel | Handshake        | Payload
// input   | push / full      | text_byte[7:0], text_last
// result  | empty / pop      | escaped_byte[7:0], run_last, text_end
//
// A plain byte yields one output byte; an escaped byte yields 4 to 7, one per
// entity character, which the back end emits one a cycle while pop is high.
// An input passes the front stage, the queue and the output register in order.
// Reset clears the front stage, the queue pointers and the output register.
// With pop low the output holds; full rises once the queue and front stage fill.
module html_entity_escaper_top
	import hee_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] text_byte,
	input  logic       text_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] escaped_byte,
	output logic       run_last,
	output logic       text_end
);

	logic      q_full;
	logic      q_push;
	hee_item_t q_item;
	logic      q_pop;
	hee_item_t q_head;
	logic      q_empty;

	hee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.text_byte (text_byte),
		.text_last (text_last),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_item)
	);

	hee_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (q_item),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_item (q_head),
		.q_empty (q_empty)
	);

	hee_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.escaped_byte (escaped_byte),
		.run_last     (run_last),
		.text_end     (text_end)
	);

endmodule

FILE: tb/html_entity_escaper_top_test.sv
module html_entity_escaper_top_test;
	import hee_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       txt_end;
	} esc_out_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       typed;
		logic [7:0] want_ch;
		logic       want_end;
	} dir_row_t;

	localparam int DIR_ROWS = 24;
	localparam int RAND_ITEMS = 76;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] text_byte;
	logic       text_last;
	logic       empty;
	logic       pop;
	logic [7:0] escaped_byte;
	logic       run_last;
	logic       text_end;

	esc_out_t pending_out[$];
	int       errors;
	int       send_idle_pct;
	int       recv_idle_pct;

	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{8'h00,    1'b0, 1'b1, 8'h00, 1'b0},
		'{8'hFF,    1'b0, 1'b1, 8'hFF, 1'b0},
		'{8'h80,    1'b1, 1'b1, 8'h80, 1'b1},
		'{8'h7F,    1'b0, 1'b1, 8'h7F, 1'b0},
		'{8'h0A,    1'b0, 1'b1, 8'h0A, 1'b0},
		'{CH_QUOT,  1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_APOS,  1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_AMP,   1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_SLASH, 1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_LT,    1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_EQ,    1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_GT,    1'b0, 1'b0, 8'h00, 1'b0},
		'{CH_GRAVE, 1'b1, 1'b0, 8'h00, 1'b0},
		'{8'h21,    1'b1, 1'b1, 8'h21, 1'b1},
		'{8'h41,    1'b1, 1'b1, 8'h41, 1'b1},
		'{CH_GT,    1'b1, 1'b0, 8'h00, 1'b0},
		'{8'h23,    1'b0, 1'b1, 8'h23, 1'b0},
		'{8'h3B,    1'b0, 1'b1, 8'h3B, 1'b0},
		'{8'h3F,    1'b0, 1'b1, 8'h3F, 1'b0},
		'{8'h61,    1'b0, 1'b1, 8'h61, 1'b0},
		'{8'h5F,    1'b1, 1'b1, 8'h5F, 1'b1},
		'{8'h55,    1'b0, 1'b1, 8'h55, 1'b0},
		'{8'hAA,    1'b0, 1'b1, 8'hAA, 1'b0},
		'{CH_AMP,   1'b1, 1'b0, 8'h00, 1'b0}
	};

	html_entity_escaper_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.text_byte(text_byte),
		.text_last(text_last),
		.empty(empty),
		.pop(pop),
		.escaped_byte(escaped_byte),
		.run_last(run_last),
		.text_end(text_end)
	);

	// expected output run for one accepted text byte
	function automatic void escape_char(input logic [7:0] b, input logic fin);
		string    ent;
		esc_out_t o;
		int       n;
		case (b)
			CH_QUOT:  ent = "&quot;";
			CH_APOS:  ent = "&#x27;";
			CH_AMP:   ent = "&amp;";
			CH_SLASH: ent = "&#x2F;";
			CH_LT:    ent = "&lt;";
			CH_EQ:    ent = "&#x3D;";
			CH_GT:    ent = "&gt;";
			CH_GRAVE: ent = "&grave;";
			default:  ent = "";
		endcase
		n = ent.len();
		if (n == 0) begin
			o.ch = b;
			o.run_end = 1'b1;
			o.txt_end = fin;
			pending_out.push_back(o);
		end else begin
			for (int k = 0; k < n; k++) begin
				o.ch = ent[k];
				o.run_end = (k == n - 1);
				o.txt_end = (k == n - 1) && fin;
				pending_out.push_back(o);
			end
		end
	endfunction

	task automatic send_char(input logic [7:0] b, input logic fin, input logic typed,
			input logic [7:0] want_ch, input logic want_end);
		esc_out_t o;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		text_byte <= b;
		text_last <= fin;
		do @(posedge clk); while (full);
		if (typed) begin
			o.ch = want_ch;
			o.run_end = 1'b1;
			o.txt_end = want_end;
			pending_out.push_back(o);
		end else begin
			escape_char(b, fin);
		end
	endtask

	task automatic send_random(input int count);
		logic [7:0] b;
		logic [7:0] specials [0:7];
		int         r;
		specials = '{CH_QUOT, CH_APOS, CH_AMP, CH_SLASH, CH_LT, CH_EQ, CH_GT, CH_GRAVE};
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 35)
				b = specials[$urandom_range(7)];
			else if (r < 55)
				b = 8'($urandom_range(255, 128));
			else if (r < 65)
				b = 8'($urandom_range(31));
			else
				b = 8'($urandom_range(255));
			send_char(b, $urandom_range(7) == 0, 1'b0, 8'h00, 1'b0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		esc_out_t want;
		if (arst_n && pop && !empty) begin
			if (pending_out.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transaction: byte %h run_last %b text_end %b",
						escaped_byte, run_last, text_end);
			end else begin
				want = pending_out.pop_front();
				if (escaped_byte !== want.ch || run_last !== want.run_end ||
						text_end !== want.txt_end) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h %b %b, got %h %b %b",
							want.ch, want.run_end, want.txt_end,
							escaped_byte, run_last, text_end);
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("html_entity_escaper_top_test: errors");
		$finish;
	end

	initial begin
		errors = 0;
		arst_n = 1'b0;
		push = 1'b0;
		text_byte = 8'h00;
		text_last = 1'b0;
		send_idle_pct = 38;
		recv_idle_pct = 63;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++)
			send_char(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].typed,
				dir_rows[i].want_ch, dir_rows[i].want_end);
		send_random(RAND_ITEMS / 3);

		send_idle_pct = 63;
		recv_idle_pct = 38;
		send_random(RAND_ITEMS / 3);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));

		@(negedge clk);
		push <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("html_entity_escaper_top_test: clean");
		else
			$display("html_entity_escaper_top_test: errors");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/hee_pkg.sv
hw/rtl/hee_front.sv
hw/rtl/hee_queue.sv
hw/rtl/hee_back.sv
hw/rtl/html_entity_escaper_top.sv
tb/html_entity_escaper_top_test.sv
